FILE: hw/rtl/wilf_pkg.sv
// Shared types, constants and byte classification functions for the
// word initial letter filter. No dependencies.
package wilf_pkg;

  localparam int MAX_WORD_DEF = 64;
  localparam logic [7:0] TARGET_RESET = 8'h41;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } wilf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       word_last;
    logic       truncated;
  } wilf_out_t;

  typedef struct packed {
    logic go;
    logic trunc;
  } wilf_start_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
           ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
  endfunction

endpackage

FILE: hw/rtl/wilf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wilf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/wilf_word.sv
// Word tracker: classifies input bytes, writes word bytes to the word RAM
// and raises an emit request at the end of a matching word. Depends on wilf_pkg.
module wilf_word import wilf_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  wilf_in_t                      item,
  input  logic [7:0]                    target_letter,
  output logic                          wr_en,
  output logic [$clog2(MAX_WORD)-1:0]   wr_addr,
  output logic [7:0]                    wr_data,
  output wilf_start_t                   start,
  output logic [$clog2(MAX_WORD+1)-1:0] start_len
);

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);
  localparam logic [LW-1:0] FULL = LW'(MAX_WORD);

  logic [LW-1:0] stored;
  logic [LW-1:0] trimmed;
  logic          overflow;
  logic [7:0]    first_byte;
  logic          word_end;
  logic          punct;
  logic          has_room;

  assign word_end = item.end_of_stream || is_space(item.in_byte);
  assign punct    = is_punct(item.in_byte);
  assign has_room = stored < FULL;

  assign wr_addr = stored[AW-1:0];
  assign wr_data = item.in_byte;
  assign wr_en   = accept && !word_end && has_room && (!punct || (stored != '0));

  assign start.go    = accept && word_end && (trimmed != '0) &&
                       (fold(first_byte) == fold(target_letter));
  assign start.trunc = overflow;
  assign start_len   = trimmed;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored   <= '0;
      trimmed  <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (word_end) begin
        stored   <= '0;
        trimmed  <= '0;
        overflow <= 1'b0;
      end else if (punct) begin
        if (wr_en) begin
          stored <= stored + 1'b1;
        end
      end else if (has_room) begin
        stored  <= stored + 1'b1;
        trimmed <= stored + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !word_end && !punct && (stored == '0)) begin
      first_byte <= item.in_byte;
    end
  end

endmodule

FILE: hw/rtl/wilf_emit.sv
// Word emitter: streams a finished word out of the word RAM, one read per
// transfer, marking the last byte. Depends on wilf_pkg.
module wilf_emit import wilf_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wilf_start_t                   start,
  input  logic [$clog2(MAX_WORD+1)-1:0] start_len,
  input  logic                          out_ready,
  input  logic [7:0]                    rd_data,
  output logic                          rd_en,
  output logic [$clog2(MAX_WORD)-1:0]   rd_addr,
  output logic                          busy,
  output wilf_out_t                     out_item
);

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic          state;
  logic          state_next;
  logic [LW-1:0] idx;
  logic [LW-1:0] len_r;
  logic          trunc;
  logic          last;
  logic          advance;

  assign busy    = (state == ST_EMIT);
  assign last    = (idx == len_r);
  assign advance = busy && out_ready && !last;
  assign rd_en   = start.go || advance;
  assign rd_addr = start.go ? '0 : idx[AW-1:0];

  assign out_item.out_byte  = rd_data;
  assign out_item.word_last = last;
  assign out_item.truncated = trunc;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start.go) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start.go) begin
      idx   <= LW'(1);
      len_r <= start_len;
      trunc <= start.trunc;
    end else if (advance) begin
      idx <= idx + 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx != '0) && (idx <= len_r))
    else $error("emit index out of range");

  a_done: assert property (@(posedge clk) disable iff (rst)
    (busy && out_ready && last) |=> !busy)
    else $error("emitter did not stop after last byte");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start.go |-> !busy)
    else $error("word start while emitting");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_ready) |=> $stable(idx) && $stable(rd_data))
    else $error("stalled output changed");
`endif

endmodule

FILE: hw/rtl/word_initial_letter_filter.sv
// Word initial letter filter, top level. Depends on wilf_pkg, wilf_ram,
// wilf_word and wilf_emit.
//
// Takes one text byte per cycle while no word is being emitted and emits
// each whitespace-delimited word, with leading punctuation dropped and
// trailing punctuation trimmed, whose first byte equals target_letter
// under ASCII case folding. A selected word blocks input while its bytes
// stream from the one read port of the word RAM, one per cycle when
// out_ready is high. Words beyond MAX_WORD bytes are cut and flagged
// truncated. No clearing pass is needed after reset.
module word_initial_letter_filter import wilf_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  wilf_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output wilf_out_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);

  logic [7:0]    target_letter;
  logic          busy;
  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  wilf_start_t   start;
  logic [LW-1:0] start_len;

  assign in_ready  = !busy;
  assign out_valid = busy;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_letter <= TARGET_RESET;
    end else if (cfg_we) begin
      target_letter <= cfg_data;
    end
  end

  wilf_word #(.MAX_WORD(MAX_WORD)) u_word (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (in_data),
    .target_letter (target_letter),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .start         (start),
    .start_len     (start_len)
  );

  wilf_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wilf_emit #(.MAX_WORD(MAX_WORD)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_len (start_len),
    .out_ready (out_ready),
    .rd_data   (rd_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .busy      (busy),
    .out_item  (out_data)
  );

endmodule
